/* rtl/dsw_pkg.sv */
// Package for the distance scale / implicit weight pipeline.
// Shared constants, mode codes and the stage payload structs.
// No dependencies.
package dsw_pkg;

   localparam int POC_W    = 32;
   localparam int DIFF_W   = POC_W + 1;
   localparam int TD_W     = 8;
   localparam int WEIGHT_W = 9;
   localparam int DIST_W   = 11;
   localparam int QUOT_W   = 15;
   localparam int DIV_STEPS  = 5;
   localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
   localparam int TX_W     = QUOT_W + 1;
   localparam int MUL_W    = TX_W + TD_W;
   localparam int PROD_W   = MUL_W + 1;
   localparam int MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_EXPLICIT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_IMPLICIT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET    = MODE_IMPLICIT;

   localparam logic [QUOT_W-1:0]         DIVIDEND_BASE = 15'd16384;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_DEFAULT = 9'sd32;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_SUM     = 9'sd64;
   localparam logic signed [WEIGHT_W-1:0] W1_MIN         = -9'sd64;
   localparam logic signed [WEIGHT_W-1:0] W1_MAX         = 9'sd128;
   localparam logic signed [DIST_W-1:0]   DIST_MIN       = -11'sd1024;
   localparam logic signed [DIST_W-1:0]   DIST_MAX       = 11'sd1023;
   localparam logic signed [PROD_W-1:0]   ROUND_BIAS     = 25'sd32;

   typedef struct packed {
      logic signed [TD_W-1:0]     tb;
      logic [TD_W-1:0]            td_mag;
      logic                       td_neg;
      logic                       td_zero;
      logic                       lt0;
      logic                       lt1;
      logic signed [WEIGHT_W-1:0] ew0;
      logic signed [WEIGHT_W-1:0] ew1;
   } item_type;

   typedef struct packed {
      item_type           item;
      logic [TD_W-1:0]    rem;
      logic [QUOT_W-1:0]  work;
   } div_type;

endpackage

/* rtl/dsw_ifs.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on dsw_pkg for field widths.
interface dsw_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dsw_pkg::POC_W-1:0]       cur_order_count;
   logic signed [dsw_pkg::POC_W-1:0]       ref0_order_count;
   logic signed [dsw_pkg::POC_W-1:0]       ref1_order_count;
   logic                                   ref0_long_term;
   logic                                   ref1_long_term;
   logic signed [dsw_pkg::WEIGHT_W-1:0]    explicit_weight0;
   logic signed [dsw_pkg::WEIGHT_W-1:0]    explicit_weight1;

   modport source (output valid, cur_order_count, ref0_order_count, ref1_order_count,
                   ref0_long_term, ref1_long_term, explicit_weight0, explicit_weight1,
                   input ready);
   modport sink (input valid, cur_order_count, ref0_order_count, ref1_order_count,
                 ref0_long_term, ref1_long_term, explicit_weight0, explicit_weight1,
                 output ready);
endinterface

interface dsw_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dsw_pkg::WEIGHT_W-1:0]    weight0;
   logic signed [dsw_pkg::WEIGHT_W-1:0]    weight1;
   logic                                   clear_offsets;
   logic signed [dsw_pkg::DIST_W-1:0]      dist_scale;
   logic                                   dist_scale_valid;

   modport source (output valid, weight0, weight1, clear_offsets, dist_scale,
                   dist_scale_valid, input ready);
   modport sink (input valid, weight0, weight1, clear_offsets, dist_scale,
                 dist_scale_valid, output ready);
endinterface

/* rtl/dsw_front.sv */
// Input stage: order count differences clipped to tb/td, divider set-up.
// Depends on dsw_pkg and dsw_req_if.
module dsw_front (
   input  logic              clock,
   input  logic              reset,
   dsw_req_if.sink           req,
   output logic              out_valid,
   input  logic              out_ready,
   output dsw_pkg::div_type  out_data
);

   logic                           valid_ff, valid_in;
   dsw_pkg::div_type               data_ff, data_in;
   logic signed [dsw_pkg::DIFF_W-1:0] tb_diff, td_diff;
   logic signed [dsw_pkg::TD_W-1:0]   tb_clip, td_clip;
   logic [dsw_pkg::TD_W-1:0]          td_mag;

   function automatic logic signed [dsw_pkg::TD_W-1:0] clip8(
         input logic signed [dsw_pkg::DIFF_W-1:0] v);
      logic fits;
      fits = (v[dsw_pkg::DIFF_W-1:dsw_pkg::TD_W-1] == '0) ||
             (v[dsw_pkg::DIFF_W-1:dsw_pkg::TD_W-1] == '1);
      if (fits) begin
         clip8 = v[dsw_pkg::TD_W-1:0];
      end else if (v[dsw_pkg::DIFF_W-1]) begin
         clip8 = 8'sh80;
      end else begin
         clip8 = 8'sh7f;
      end
   endfunction

   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      tb_diff = dsw_pkg::DIFF_W'(req.cur_order_count) -
                dsw_pkg::DIFF_W'(req.ref0_order_count);
      td_diff = dsw_pkg::DIFF_W'(req.ref1_order_count) -
                dsw_pkg::DIFF_W'(req.ref0_order_count);
      tb_clip = clip8(tb_diff);
      td_clip = clip8(td_diff);
      td_mag  = td_clip[dsw_pkg::TD_W-1] ? dsw_pkg::TD_W'(-td_clip) : td_clip;

      data_in              = data_ff;
      data_in.item.tb      = tb_clip;
      data_in.item.td_mag  = td_mag;
      data_in.item.td_neg  = td_clip[dsw_pkg::TD_W-1];
      data_in.item.td_zero = (td_clip == '0);
      data_in.item.lt0     = req.ref0_long_term;
      data_in.item.lt1     = req.ref1_long_term;
      data_in.item.ew0     = req.explicit_weight0;
      data_in.item.ew1     = req.explicit_weight1;
      data_in.rem          = '0;
      data_in.work         = dsw_pkg::DIVIDEND_BASE +
                             dsw_pkg::QUOT_W'(td_mag[dsw_pkg::TD_W-1:1]);
      if (!(req.valid && req.ready)) begin
         data_in = data_ff;
      end
      valid_in = req.ready ? req.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/dsw_div_stage.sv */
// One stage of the restoring divider: a fixed number of quotient bits a beat.
// Depends on dsw_pkg.
module dsw_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dsw_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dsw_pkg::div_type  out_data
);

   logic                        valid_ff, valid_in;
   dsw_pkg::div_type            data_ff, data_in;
   logic [dsw_pkg::TD_W:0]      trial;
   logic [dsw_pkg::TD_W-1:0]    rem_v;
   logic [dsw_pkg::QUOT_W-1:0]  work_v;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rem_v  = in_data.rem;
      work_v = in_data.work;
      trial  = '0;
      for (int i = 0; i < dsw_pkg::DIV_STEPS; i++) begin
         trial  = {rem_v, work_v[dsw_pkg::QUOT_W-1]};
         work_v = {work_v[dsw_pkg::QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, in_data.item.td_mag}) begin
            trial     = trial - {1'b0, in_data.item.td_mag};
            work_v[0] = 1'b1;
         end
         rem_v = trial[dsw_pkg::TD_W-1:0];
      end
      data_in = data_ff;
      if (in_valid && in_ready) begin
         data_in.item = in_data.item;
         data_in.rem  = rem_v;
         data_in.work = work_v;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/dsw_scale.sv */
// Back end: signed multiply by tb, then rounding, clipping and weight select
// into the response register. Depends on dsw_pkg and dsw_rsp_if.
module dsw_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dsw_pkg::MODE_W-1:0]    mode,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dsw_pkg::div_type              in_data,
   dsw_rsp_if.source                     rsp
);

   // multiply stage
   logic                                 mul_valid_ff, mul_valid_in, mul_ready;
   logic signed [dsw_pkg::PROD_W-1:0]    prod_ff, prod_in;
   dsw_pkg::item_type                    mitem_ff, mitem_in;
   logic signed [dsw_pkg::TX_W-1:0]      tx;
   logic signed [dsw_pkg::TD_W-1:0]      tb_s;
   logic signed [dsw_pkg::MUL_W-1:0]     mul;

   // response stage
   logic                                 out_valid_ff, out_valid_in;
   logic signed [dsw_pkg::WEIGHT_W-1:0]  w0_ff, w0_in, w1_ff, w1_in;
   logic                                 clr_ff, clr_in;
   logic signed [dsw_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic                                 dvalid_ff, dvalid_in;
   logic signed [dsw_pkg::PROD_W-7:0]    shifted;
   logic signed [dsw_pkg::DIST_W-1:0]    dist_c;
   logic signed [dsw_pkg::WEIGHT_W-1:0]  iw1;
   logic signed [dsw_pkg::WEIGHT_W:0]    wsum;

   assign mul_ready = !out_valid_ff || rsp.ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   always_comb begin
      tx = in_data.item.td_neg ? -$signed({1'b0, in_data.work})
                               :  $signed({1'b0, in_data.work});
      tb_s = in_data.item.tb;
      mul  = tx * tb_s;
      prod_in  = prod_ff;
      mitem_in = mitem_ff;
      if (in_valid && in_ready) begin
         prod_in  = dsw_pkg::PROD_W'(mul) + dsw_pkg::ROUND_BIAS;
         mitem_in = in_data.item;
      end
      mul_valid_in = in_ready ? in_valid : mul_valid_ff;
   end

   always_comb begin
      shifted = prod_ff[dsw_pkg::PROD_W-1:6];
      if ((shifted[dsw_pkg::PROD_W-7:dsw_pkg::DIST_W-1] == '0) ||
          (shifted[dsw_pkg::PROD_W-7:dsw_pkg::DIST_W-1] == '1)) begin
         dist_c = shifted[dsw_pkg::DIST_W-1:0];
      end else if (shifted[dsw_pkg::PROD_W-7]) begin
         dist_c = dsw_pkg::DIST_MIN;
      end else begin
         dist_c = dsw_pkg::DIST_MAX;
      end
      if (mitem_ff.td_zero) begin
         dist_c = '0;
      end
      iw1 = dist_c[dsw_pkg::DIST_W-1:2];

      w0_in     = dsw_pkg::WEIGHT_DEFAULT;
      w1_in     = dsw_pkg::WEIGHT_DEFAULT;
      clr_in    = 1'b0;
      if (mode == dsw_pkg::MODE_EXPLICIT) begin
         w0_in = mitem_ff.ew0;
         w1_in = mitem_ff.ew1;
      end else if (mode == dsw_pkg::MODE_IMPLICIT && !mitem_ff.td_zero &&
                   !mitem_ff.lt0 && !mitem_ff.lt1) begin
         if (iw1 < dsw_pkg::W1_MIN || iw1 > dsw_pkg::W1_MAX) begin
            clr_in = 1'b1;
         end else begin
            w0_in = dsw_pkg::WEIGHT_SUM - iw1;
            w1_in = iw1;
         end
      end
      dist_in   = dist_c;
      dvalid_in = !mitem_ff.td_zero;
      if (!(mul_valid_ff && mul_ready)) begin
         w0_in     = w0_ff;
         w1_in     = w1_ff;
         clr_in    = clr_ff;
         dist_in   = dist_ff;
         dvalid_in = dvalid_ff;
      end
      out_valid_in = mul_ready ? mul_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff   <= prod_in;
      mitem_ff  <= mitem_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      clr_ff    <= clr_in;
      dist_ff   <= dist_in;
      dvalid_ff <= dvalid_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.weight0          = w0_ff;
   assign rsp.weight1          = w1_ff;
   assign rsp.clear_offsets    = clr_ff;
   assign rsp.dist_scale       = dist_ff;
   assign rsp.dist_scale_valid = dvalid_ff;

   assign wsum = {w0_ff[dsw_pkg::WEIGHT_W-1], w0_ff} + {w1_ff[dsw_pkg::WEIGHT_W-1], w1_ff};

   a_zero_td : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !dvalid_ff |-> dist_ff == '0 && !clr_ff)
      else $error("zero td beat with nonzero scale or cleared offsets");

   a_clear_default : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && clr_ff |-> w0_ff == dsw_pkg::WEIGHT_DEFAULT &&
                                 w1_ff == dsw_pkg::WEIGHT_DEFAULT)
      else $error("cleared offsets without default weights");

   a_implicit_sum : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && mode == dsw_pkg::MODE_IMPLICIT |->
         wsum == 10'sd64)
      else $error("implicit weights do not sum to 64");

endmodule

/* rtl/poc_distance_scale_weights_unit.sv */
// Pipeline from request beat to response beat: clip, three divider stages of
// five quotient bits, multiply, round/clip/weight register.
// Throughput: one beat per cycle while rsp_ch is ready; the divider is fully pipelined.
// Reset (synchronous, active high) empties the pipeline and sets the mode
// register to implicit weighting.
// Depends on dsw_pkg, dsw_ifs, dsw_front, dsw_div_stage and dsw_scale.
module poc_distance_scale_weights_unit (
   input  logic                        clock,
   input  logic                        reset,
   dsw_req_if.sink                     req_ch,
   dsw_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [dsw_pkg::MODE_W-1:0]  csr_wdata
);

   logic [dsw_pkg::MODE_W-1:0]   mode_ff, mode_in;
   dsw_pkg::div_type             chain_data  [0:dsw_pkg::DIV_STAGES];
   logic                         chain_valid [0:dsw_pkg::DIV_STAGES];
   logic                         chain_ready [0:dsw_pkg::DIV_STAGES];

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dsw_pkg::MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   dsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar g = 0; g < dsw_pkg::DIV_STAGES; g++) begin : g_div
      dsw_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   dsw_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .in_valid (chain_valid[dsw_pkg::DIV_STAGES]),
      .in_ready (chain_ready[dsw_pkg::DIV_STAGES]),
      .in_data  (chain_data[dsw_pkg::DIV_STAGES]),
      .rsp      (rsp_ch)
   );

endmodule
